@@ hw/rtl/klst_pkg.sv @@
// ----------------------------------------------------------------------------
// klst_pkg
// Shared types and constants of the keyed latency statistics table.
// ----------------------------------------------------------------------------
`default_nettype none

package klst_pkg;

  localparam int TableEntriesDef = 64;
  localparam int NumStats        = 6;

  localparam logic [1:0] TAB_REQ = 2'd0;
  localparam logic [1:0] TAB_IP  = 2'd1;
  localparam logic [1:0] TAB_SRV = 2'd2;

  localparam logic [2:0] ST_ICALLS = 3'd0;
  localparam logic [2:0] ST_ITICKS = 3'd1;
  localparam logic [2:0] ST_IMAX   = 3'd2;
  localparam logic [2:0] ST_TCALLS = 3'd3;
  localparam logic [2:0] ST_TTICKS = 3'd4;
  localparam logic [2:0] ST_TMAX   = 3'd5;

  localparam logic [1:0] REG_MEAS = 2'd0;
  localparam logic [1:0] REG_SRV  = 2'd1;
  localparam logic [1:0] REG_IP   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the input item
    logic       scan_clr;  // reset the scan counters
    logic       scan_step; // examine one slot
    logic [1:0] tab;       // table in use
    logic       rd_issue;  // read stats word
    logic       wr_issue;  // write stats word
    logic       claim;     // write key and valid of a new slot
    logic       drop;      // note a dropped record
    logic       free_slot; // clear valid of the read slot
    logic       emit;      // present the result
  } klst_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic has_free;
    logic word_last;
  } klst_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/klst_ram.sv @@
// ----------------------------------------------------------------------------
// klst_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module klst_ram #(
  parameter int Width = 64,
  parameter int Depth = 384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/klst_datapath.sv @@
// ----------------------------------------------------------------------------
// klst_datapath
// Key scan, stats read-modify-write and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module klst_datapath
  import klst_pkg::*;
#(
  parameter int TableEntries = TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire klst_cmd_t   cmd,
  output klst_sts_t        sts,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_request_id,
  input  wire logic [31:0] in_source_ip,
  input  wire logic [31:0] in_server_key,
  input  wire logic [63:0] in_start_tick,
  input  wire logic [63:0] in_stop_tick,
  input  wire logic [1:0]  in_table_select,
  input  wire logic [5:0]  in_slot_index,
  input  wire logic        in_clear_interval,
  input  wire logic        in_clear_total,
  output logic             out_slot_valid,
  output logic [31:0]      out_slot_key,
  output logic [31:0]      out_interval_calls,
  output logic [63:0]      out_interval_ticks,
  output logic [63:0]      out_interval_max,
  output logic [63:0]      out_total_calls,
  output logic [63:0]      out_total_ticks,
  output logic [63:0]      out_total_max,
  output logic             out_record_dropped
);

  localparam int IdxW   = $clog2(TableEntries);
  localparam int CntW   = $clog2(TableEntries + 1);
  localparam int SDepth = TableEntries * NumStats;
  localparam int SAddrW = $clog2(SDepth);

  // Captured item.
  logic        rd_r;
  logic [31:0] req_r, ip_r, srv_r;
  logic [63:0] cost_r;
  logic [1:0]  sel_r;
  logic        clri_r, clrt_r;

  // Scan state.
  logic [CntW-1:0] scan_r;
  logic            hit_r, free_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r, slot_r;
  logic [2:0]      word_r, rword_r;
  logic            rvalid_r;
  logic            drop_r;

  logic [TableEntries-1:0] vld_r [3];
  logic [31:0]             key_q [3];
  logic [63:0]             st_q  [3];
  logic [63:0]             wdata;
  logic [63:0]             res_r [NumStats];
  logic                    res_v_r;
  logic [31:0]             res_k_r;

  logic [IdxW-1:0]   key_addr;
  logic [SAddrW-1:0] st_addr;
  logic [2:0]        key_we, st_we;
  logic              is_new;
  logic              is_read;

  // A read addresses the key of the selected slot; a record scans all keys.
  assign is_read  = rd_r;
  assign key_addr = (cmd.claim || is_read) ? slot_r : scan_r[IdxW-1:0];
  assign st_addr  = SAddrW'(slot_r) * SAddrW'(NumStats) + SAddrW'(word_r);
  assign is_new   = !is_read && !hit_r;

  // Next stats word value: zero for a freshly claimed slot's old contents.
  logic [63:0] cur;
  logic [64:0] sum;
  always_comb begin
    cur   = is_new ? 64'd0 : st_q[cmd.tab];
    sum   = {1'b0, cur} + {1'b0, cost_r};
    wdata = cur;
    if (is_read) begin
      wdata = cur;
      if (clri_r && (word_r inside {ST_ICALLS, ST_ITICKS, ST_IMAX})) begin
        wdata = 64'd0;
      end
      if (clrt_r && (sel_r != TAB_REQ || (word_r inside {ST_TCALLS, ST_TTICKS, ST_TMAX})))
      begin
        wdata = 64'd0;
      end
    end else begin
      case (word_r)
        ST_ICALLS: wdata = (cur[31:0] == 32'hFFFF_FFFF) ? cur : cur + 64'd1;
        ST_TCALLS: wdata = (cur == 64'hFFFF_FFFF_FFFF_FFFF) ? cur : cur + 64'd1;
        ST_ITICKS, ST_TTICKS: wdata = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
        ST_IMAX, ST_TMAX: wdata = (cost_r > cur) ? cost_r : cur;
        default: wdata = cur;
      endcase
    end
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      key_we[t] = cmd.claim && (cmd.tab == 2'(t));
      st_we[t]  = cmd.wr_issue && (cmd.tab == 2'(t));
    end
  end

  logic [31:0] want_key;
  always_comb begin
    case (cmd.tab)
      TAB_IP:  want_key = ip_r;
      TAB_SRV: want_key = srv_r;
      default: want_key = req_r;
    endcase
  end

  for (genvar t = 0; t < 3; t++) begin : g_tab
    klst_ram #(.Width(32), .Depth(TableEntries)) u_key (
      .clk(clk), .we(key_we[t]), .addr(key_addr), .wdata(want_key), .rdata(key_q[t])
    );
    klst_ram #(.Width(64), .Depth(SDepth)) u_st (
      .clk(clk), .we(st_we[t]), .addr(st_addr), .wdata(wdata), .rdata(st_q[t])
    );
  end

  // Scan pipeline: key read issued at scan_r, compared in the cycle after.
  logic [IdxW-1:0] cmp_idx_r;
  logic            cmp_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 3; t++) vld_r[t] <= '0;
      cmp_v_r  <= 1'b0;
      rvalid_r <= 1'b0;
      out_record_dropped <= 1'b0;
    end else begin
      cmp_v_r  <= cmd.scan_step && (scan_r < CntW'(TableEntries));
      rvalid_r <= cmd.rd_issue;
      if (cmd.claim) vld_r[cmd.tab][slot_r] <= 1'b1;
      if (cmd.free_slot) vld_r[sel_r][slot_r] <= 1'b0;
      if (cmd.emit) out_record_dropped <= !rd_r && drop_r;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_r[IdxW-1:0];
    rword_r   <= word_r;
    if (cmd.load) begin
      rd_r   <= in_cmd;
      req_r  <= in_request_id;
      ip_r   <= in_source_ip;
      srv_r  <= in_server_key;
      cost_r <= (in_stop_tick < in_start_tick) ? 64'd0 : in_stop_tick - in_start_tick;
      sel_r  <= in_table_select;
      clri_r <= in_clear_interval;
      clrt_r <= in_clear_total;
      drop_r <= 1'b0;
      slot_r <= IdxW'(in_slot_index);
      for (int w = 0; w < NumStats; w++) res_r[w] <= '0;
      res_v_r <= 1'b0;
      res_k_r <= '0;
    end
    if (cmd.drop) drop_r <= 1'b1;
    if (cmd.scan_clr) begin
      scan_r <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      word_r <= '0;
    end else if (cmd.scan_step) begin
      if (scan_r < CntW'(TableEntries + 1)) scan_r <= scan_r + CntW'(1);
    end
    if (cmp_v_r && !cmd.scan_clr) begin
      if (vld_r[cmd.tab][cmp_idx_r]) begin
        if (!hit_r && key_q[cmd.tab] == want_key) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
      end else if (!free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= cmp_idx_r;
      end
    end
    if (sts.scan_done && cmd.rd_issue && word_r == 3'd0) begin
      slot_r <= hit_r ? hit_idx_r : free_idx_r;
    end
    if (cmd.wr_issue) word_r <= word_r + 3'd1;
    // A free slot reads as all zero; its RAM words are never initialized.
    if (is_read && rvalid_r) begin
      res_r[rword_r] <= vld_r[sel_r][slot_r] ? st_q[sel_r] : 64'd0;
      res_v_r <= vld_r[sel_r][slot_r];
      res_k_r <= vld_r[sel_r][slot_r] ? key_q[sel_r] : 32'd0;
    end
    if (cmd.emit) begin
      out_slot_valid     <= res_v_r;
      out_slot_key       <= res_k_r;
      out_interval_calls <= res_r[ST_ICALLS][31:0];
      out_interval_ticks <= res_r[ST_ITICKS];
      out_interval_max   <= res_r[ST_IMAX];
      out_total_calls    <= res_r[ST_TCALLS];
      out_total_ticks    <= res_r[ST_TTICKS];
      out_total_max      <= res_r[ST_TMAX];
    end
  end

  assign sts.scan_done = (scan_r == CntW'(TableEntries + 1));
  assign sts.hit       = hit_r;
  assign sts.has_free  = free_r;
  assign sts.word_last = (word_r == 3'(NumStats - 1));

endmodule

`default_nettype wire

@@ hw/rtl/klst_ctrl.sv @@
// ----------------------------------------------------------------------------
// klst_ctrl
// Sequencer for record and read items.
// ----------------------------------------------------------------------------
`default_nettype none

module klst_ctrl
  import klst_pkg::*;
#(
  parameter int TableEntries = TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        in_cmd,
  input  wire logic [1:0]  in_table_select,
  input  wire logic [5:0]  in_slot_index,
  input  wire logic        in_clear_total,
  input  wire logic [31:0] in_source_ip,
  input  wire logic [31:0] in_server_key,
  input  wire logic        measure_enable,
  input  wire logic        key_by_server,
  input  wire logic        key_by_ip,
  input  wire klst_sts_t   sts,
  output klst_cmd_t        cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SCAN = 8'b0000_0010,
    S_DEC  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_WAIT = 8'b0001_0000,
    S_WR   = 8'b0010_0000,
    S_NEXT = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] tab_r, tab_nxt;
  logic [1:0] tab2_r, tab2_nxt;
  logic       two_r, two_nxt;
  logic       rd_r, rd_nxt;
  logic       clrt_r, clrt_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    tab_nxt   = tab_r;
    tab2_nxt  = tab2_r;
    two_nxt   = two_r;
    rd_nxt    = rd_r;
    clrt_nxt  = clrt_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    cmd.tab   = tab_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          rd_nxt       = in_cmd;
          clrt_nxt     = in_clear_total;
          if (in_cmd) begin
            tab_nxt = in_table_select;
            if (in_table_select == 2'd3 ||
                32'(in_slot_index) >= 32'(TableEntries)) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RD;
            end
          end else if (!measure_enable) begin
            state_nxt = S_EMIT;
          end else begin
            tab_nxt   = TAB_REQ;
            two_nxt   = (key_by_server && in_server_key != 32'd0) ||
                        (key_by_ip && in_source_ip != 32'd0);
            tab2_nxt  = (key_by_server && in_server_key != 32'd0) ? TAB_SRV : TAB_IP;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!sts.hit && !sts.has_free) begin
          cmd.drop  = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          cmd.rd_issue = 1'b1;
          cmd.claim    = 1'b0;
          state_nxt    = S_WAIT;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_issue = 1'b1;
        if (sts.word_last) begin
          if (!rd_r && !sts.hit) cmd.claim = 1'b1;
          if (rd_r && clrt_r && tab_r != TAB_REQ) cmd.free_slot = 1'b1;
          state_nxt = rd_r ? S_EMIT : S_NEXT;
        end else begin
          state_nxt = rd_r ? S_RD : S_DEC;
        end
      end
      S_NEXT: begin
        if (two_r) begin
          two_nxt      = 1'b0;
          tab_nxt      = tab2_r;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tab_r   <= TAB_REQ;
      tab2_r  <= TAB_REQ;
      two_r   <= 1'b0;
      rd_r    <= 1'b0;
      clrt_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tab_r   <= tab_nxt;
      tab2_r  <= tab2_nxt;
      two_r   <= two_nxt;
      rd_r    <= rd_nxt;
      clrt_r  <= clrt_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/keyed_latency_statistics_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_latency_statistics_table_unit
// Per-request, per-ip and per-server call latency statistics tables.
// ----------------------------------------------------------------------------
// A record item runs, for each table it touches, a key scan reading one slot
// key a cycle, then a read-modify-write of six stats words on a single-port
// RAM; a record that also touches the ip or server table repeats both on that
// table. The result appears for one cycle with out_valid, and busy stays high
// until the cycle after, so the next transfer is taken once out_valid has
// dropped. Results cannot be held off by the receiver. The user must write
// configuration over the APB port only while the block is idle; the block
// itself does not enforce it.
`default_nettype none

module keyed_latency_statistics_table_unit
  import klst_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [31:0] in_request_id,
  input  wire logic [31:0] in_source_ip,
  input  wire logic [31:0] in_server_key,
  input  wire logic [63:0] in_start_tick,
  input  wire logic [63:0] in_stop_tick,
  input  wire logic [1:0]  in_table_select,
  input  wire logic [5:0]  in_slot_index,
  input  wire logic        in_clear_interval,
  input  wire logic        in_clear_total,
  output logic             out_valid,
  output logic             out_slot_valid,
  output logic [31:0]      out_slot_key,
  output logic [31:0]      out_interval_calls,
  output logic [63:0]      out_interval_ticks,
  output logic [63:0]      out_interval_max,
  output logic [63:0]      out_total_calls,
  output logic [63:0]      out_total_ticks,
  output logic [63:0]      out_total_max,
  output logic             out_record_dropped,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic meas_r, srv_r, ip_r;
  logic wr_en;
  klst_cmd_t cmd;
  klst_sts_t sts;
  logic      acc;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r <= 1'b0;
      srv_r  <= 1'b0;
      ip_r   <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MEAS: meas_r <= pwdata[0];
        REG_SRV:  srv_r  <= pwdata[0];
        REG_IP:   ip_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MEAS: prdata = {31'd0, meas_r};
      REG_SRV:  prdata = {31'd0, srv_r};
      REG_IP:   prdata = {31'd0, ip_r};
      default:  prdata = 32'd0;
    endcase
  end

  klst_ctrl #(.TableEntries(TABLE_ENTRIES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc), .in_cmd(in_cmd),
    .in_table_select(in_table_select), .in_slot_index(in_slot_index),
    .in_clear_total(in_clear_total), .in_source_ip(in_source_ip),
    .in_server_key(in_server_key), .measure_enable(meas_r),
    .key_by_server(srv_r), .key_by_ip(ip_r), .sts(sts), .cmd(cmd),
    .busy(busy), .done(out_valid)
  );

  klst_datapath #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_cmd(in_cmd), .in_request_id(in_request_id), .in_source_ip(in_source_ip),
    .in_server_key(in_server_key), .in_start_tick(in_start_tick),
    .in_stop_tick(in_stop_tick), .in_table_select(in_table_select),
    .in_slot_index(in_slot_index), .in_clear_interval(in_clear_interval),
    .in_clear_total(in_clear_total),
    .out_slot_valid(out_slot_valid), .out_slot_key(out_slot_key),
    .out_interval_calls(out_interval_calls), .out_interval_ticks(out_interval_ticks),
    .out_interval_max(out_interval_max), .out_total_calls(out_total_calls),
    .out_total_ticks(out_total_ticks), .out_total_max(out_total_max),
    .out_record_dropped(out_record_dropped)
  );

endmodule

`default_nettype wire

@@ hw/rtl/klst_checker.sv @@
// ----------------------------------------------------------------------------
// klst_checker
// Port-level checks of the statistics table unit.
// ----------------------------------------------------------------------------
`default_nettype none

module klst_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_record_dropped,
  input wire logic out_slot_valid,
  input wire logic pready
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");

  a_valid_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside an item");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");

  a_drop_only_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_dropped |-> !out_slot_valid) else $error("mixed result");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind keyed_latency_statistics_table_unit klst_checker u_klst_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_record_dropped(out_record_dropped), .out_slot_valid(out_slot_valid),
  .pready(pready)
);

`default_nettype wire

@@ tb/keyed_latency_statistics_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// keyed_latency_statistics_table_unit_tb
// Self-checking bench for the keyed latency statistics table unit.
// ----------------------------------------------------------------------------
// A directed table of record and read commands comes first. It covers the
// state after reset, the largest costs, saturation, negative spans and a bad
// table select. Random traffic follows under several keying setups. Each
// accepted command is run through a behavioral copy of the three tables. The
// strobed results are compared in order against that copy or a fixed result.
`default_nettype none

module keyed_latency_statistics_table_unit_tb;
  import klst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          Slots      = 64;
  localparam int          IdleLimit  = 5000;
  localparam logic        CMD_RECORD = 1'b0;
  localparam logic        CMD_READ   = 1'b1;
  localparam logic [1:0]  TAB_BAD    = 2'd3;
  localparam logic [63:0] TICK_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        cmd;
    logic [31:0] req_id;
    logic [31:0] src_ip;
    logic [31:0] srv_key;
    logic [63:0] t_start;
    logic [63:0] t_stop;
    logic [1:0]  tab_sel;
    logic [5:0]  slot;
    logic        clr_int;
    logic        clr_tot;
  } cmd_item_t;

  typedef struct {
    logic        slot_valid;
    logic [31:0] slot_key;
    logic [31:0] icalls;
    logic [63:0] iticks;
    logic [63:0] imax;
    logic [63:0] tcalls;
    logic [63:0] tticks;
    logic [63:0] tmax;
    logic        dropped;
  } slot_report_t;

  // One directed row: the command, and a hand-written result where one applies.
  typedef struct {
    cmd_item_t    item;
    bit           fixed;
    slot_report_t report;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [31:0] in_request_id;
  logic [31:0] in_source_ip;
  logic [31:0] in_server_key;
  logic [63:0] in_start_tick;
  logic [63:0] in_stop_tick;
  logic [1:0]  in_table_select;
  logic [5:0]  in_slot_index;
  logic        in_clear_interval;
  logic        in_clear_total;
  logic        out_valid;
  logic        out_slot_valid;
  logic [31:0] out_slot_key;
  logic [31:0] out_interval_calls;
  logic [63:0] out_interval_ticks;
  logic [63:0] out_interval_max;
  logic [63:0] out_total_calls;
  logic [63:0] out_total_ticks;
  logic [63:0] out_total_max;
  logic        out_record_dropped;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  keyed_latency_statistics_table_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_request_id(in_request_id), .in_source_ip(in_source_ip),
    .in_server_key(in_server_key), .in_start_tick(in_start_tick),
    .in_stop_tick(in_stop_tick), .in_table_select(in_table_select),
    .in_slot_index(in_slot_index), .in_clear_interval(in_clear_interval),
    .in_clear_total(in_clear_total), .out_valid(out_valid),
    .out_slot_valid(out_slot_valid), .out_slot_key(out_slot_key),
    .out_interval_calls(out_interval_calls), .out_interval_ticks(out_interval_ticks),
    .out_interval_max(out_interval_max), .out_total_calls(out_total_calls),
    .out_total_ticks(out_total_ticks), .out_total_max(out_total_max),
    .out_record_dropped(out_record_dropped), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the three tables and of the keying registers.
  bit          shadow_valid [3][Slots];
  logic [31:0] shadow_key   [3][Slots];
  logic [63:0] shadow_stats [3][Slots][NumStats];
  bit          meas_on;
  bit          srv_keying;
  bit          ip_keying;

  slot_report_t pending_reports[$];
  int           n_errors;
  int           n_sent;
  int           n_seen;
  int           n_records;
  int           n_reads;
  int           n_drops;
  int           idle_cycles;
  logic [31:0]  key_pool[$];

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? TICK_MAX : s[63:0];
  endfunction

  // Adds one call to the slot of key k; returns 0 when the table is full.
  function automatic bit account_call(int tab, logic [31:0] k, logic [63:0] cost);
    int hit;
    int fre;
    hit = -1;
    fre = -1;
    for (int i = 0; i < Slots; i++) begin
      if (shadow_valid[tab][i]) begin
        if (hit < 0 && shadow_key[tab][i] == k) hit = i;
      end else if (fre < 0) begin
        fre = i;
      end
    end
    if (hit < 0) begin
      if (fre < 0) return 1'b0;
      hit = fre;
      shadow_valid[tab][hit] = 1'b1;
      shadow_key[tab][hit] = k;
      for (int w = 0; w < NumStats; w++) shadow_stats[tab][hit][w] = '0;
    end
    if (shadow_stats[tab][hit][ST_ICALLS] < 64'hFFFF_FFFF)
      shadow_stats[tab][hit][ST_ICALLS]++;
    shadow_stats[tab][hit][ST_ITICKS] = sat_sum(shadow_stats[tab][hit][ST_ITICKS], cost);
    if (cost > shadow_stats[tab][hit][ST_IMAX]) shadow_stats[tab][hit][ST_IMAX] = cost;
    if (shadow_stats[tab][hit][ST_TCALLS] != TICK_MAX) shadow_stats[tab][hit][ST_TCALLS]++;
    shadow_stats[tab][hit][ST_TTICKS] = sat_sum(shadow_stats[tab][hit][ST_TTICKS], cost);
    if (cost > shadow_stats[tab][hit][ST_TMAX]) shadow_stats[tab][hit][ST_TMAX] = cost;
    return 1'b1;
  endfunction

  // Applies one command to the shadow tables and returns the expected result.
  function automatic slot_report_t apply_command(cmd_item_t it);
    slot_report_t r;
    logic [63:0]  cost;
    int           t;
    r = '{default: '0};
    if (it.cmd == CMD_RECORD) begin
      if (!meas_on) return r;
      cost = (it.t_stop < it.t_start) ? 64'd0 : it.t_stop - it.t_start;
      if (!account_call(TAB_REQ, it.req_id, cost)) r.dropped = 1'b1;
      if (srv_keying && it.srv_key != 0) begin
        if (!account_call(TAB_SRV, it.srv_key, cost)) r.dropped = 1'b1;
      end else if (ip_keying && it.src_ip != 0) begin
        if (!account_call(TAB_IP, it.src_ip, cost)) r.dropped = 1'b1;
      end
      return r;
    end
    if (it.tab_sel == TAB_BAD || it.slot >= Slots) return r;
    t = it.tab_sel;
    r.slot_valid = shadow_valid[t][it.slot];
    r.slot_key   = shadow_valid[t][it.slot] ? shadow_key[t][it.slot] : 32'd0;
    r.icalls     = shadow_stats[t][it.slot][ST_ICALLS][31:0];
    r.iticks     = shadow_stats[t][it.slot][ST_ITICKS];
    r.imax       = shadow_stats[t][it.slot][ST_IMAX];
    r.tcalls     = shadow_stats[t][it.slot][ST_TCALLS];
    r.tticks     = shadow_stats[t][it.slot][ST_TTICKS];
    r.tmax       = shadow_stats[t][it.slot][ST_TMAX];
    if (it.clr_int) begin
      shadow_stats[t][it.slot][ST_ICALLS] = '0;
      shadow_stats[t][it.slot][ST_ITICKS] = '0;
      shadow_stats[t][it.slot][ST_IMAX]   = '0;
    end
    if (it.clr_tot) begin
      // Request slots keep their key; ip and server slots are released.
      if (it.tab_sel == TAB_REQ) begin
        shadow_stats[t][it.slot][ST_TCALLS] = '0;
        shadow_stats[t][it.slot][ST_TTICKS] = '0;
        shadow_stats[t][it.slot][ST_TMAX]   = '0;
      end else begin
        shadow_valid[t][it.slot] = 1'b0;
        shadow_key[t][it.slot] = '0;
        for (int w = 0; w < NumStats; w++) shadow_stats[t][it.slot][w] = '0;
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Result monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    slot_report_t e;
    if (rst_n && out_valid) begin
      n_seen++;
      if (pending_reports.size() == 0) begin
        n_errors++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        e = pending_reports.pop_front();
        compare_field("slot_valid", e.slot_valid, out_slot_valid);
        compare_field("slot_key", e.slot_key, out_slot_key);
        compare_field("interval_calls", e.icalls, out_interval_calls);
        compare_field("interval_ticks", e.iticks, out_interval_ticks);
        compare_field("interval_max", e.imax, out_interval_max);
        compare_field("total_calls", e.tcalls, out_total_calls);
        compare_field("total_ticks", e.tticks, out_total_ticks);
        compare_field("total_max", e.tmax, out_total_max);
        compare_field("record_dropped", e.dropped, out_record_dropped);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("keyed_latency_statistics_table_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one command and waits for the edge that accepts it. The shadow model
  // is updated at that edge, and a row may force its own expected result.
  task automatic send_command(cmd_item_t it, bit fixed, slot_report_t fixed_report);
    slot_report_t r;
    @(negedge clk);
    start             = 1'b1;
    in_cmd            = it.cmd;
    in_request_id     = it.req_id;
    in_source_ip      = it.src_ip;
    in_server_key     = it.srv_key;
    in_start_tick     = it.t_start;
    in_stop_tick      = it.t_stop;
    in_table_select   = it.tab_sel;
    in_slot_index     = it.slot;
    in_clear_interval = it.clr_int;
    in_clear_total    = it.clr_tot;
    do @(posedge clk); while (busy);
    r = apply_command(it);
    pending_reports.push_back(fixed ? fixed_report : r);
    n_sent++;
    if (it.cmd == CMD_RECORD) n_records++;
    else n_reads++;
    if (r.dropped) n_drops++;
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Waits until every expected result has come and the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, bit value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {31'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_keying(bit meas, bit by_srv, bit by_ip);
    write_register(REG_MEAS, meas);
    write_register(REG_SRV, by_srv);
    write_register(REG_IP, by_ip);
    meas_on    = meas;
    srv_keying = by_srv;
    ip_keying  = by_ip;
  endtask

  function automatic logic [31:0] pick_key(int zero_pct);
    if ($urandom_range(99) < zero_pct) return 32'd0;
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // Random command: mostly records on a key pool slightly larger than a table,
  // so that tables fill up and drop; reads favor the low, occupied slots.
  function automatic cmd_item_t random_command();
    cmd_item_t it;
    it.req_id  = pick_key(0);
    it.src_ip  = pick_key(20);
    it.srv_key = pick_key(30);
    it.t_start = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       it.t_stop = {$urandom, $urandom};
      1:       it.t_stop = it.t_start - 64'($urandom_range(1, 1000));
      2: begin
        it.t_start = 64'($urandom_range(0, 15));
        it.t_stop  = TICK_MAX - 64'($urandom_range(0, 15));
      end
      default: it.t_stop = it.t_start + 64'($urandom_range(0, 100000));
    endcase
    it.slot    = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
    it.tab_sel = ($urandom_range(19) == 0) ? TAB_BAD : 2'($urandom_range(0, 2));
    it.clr_int = $urandom_range(2) == 0;
    it.clr_tot = $urandom_range(3) == 0;
    it.cmd     = ($urandom_range(99) < 65) ? CMD_RECORD : CMD_READ;
    return it;
  endfunction

  directed_row_t directed_rows[$];

  function automatic directed_row_t make_row(logic cmd, logic [31:0] req, logic [31:0] ip,
                                             logic [31:0] srv, logic [63:0] t0,
                                             logic [63:0] t1, logic [1:0] sel,
                                             logic [5:0] slot, logic ci, logic ct,
                                             bit fixed);
    directed_row_t d;
    d.item   = '{cmd, req, ip, srv, t0, t1, sel, slot, ci, ct};
    d.fixed  = fixed;
    d.report = '{default: '0};
    return d;
  endfunction

  localparam int PreEnableRows = 3;

  initial begin
    cmd_item_t    it;
    slot_report_t none;
    directed_row_t d;
    int           burst;
    int           phase_items;
    int           cfg_list[6];

    none = '{default: '0};
    n_errors = 0; n_sent = 0; n_seen = 0; n_records = 0; n_reads = 0; n_drops = 0;
    idle_cycles = 0;
    for (int t = 0; t < 3; t++)
      for (int s = 0; s < Slots; s++) begin
        shadow_valid[t][s] = 1'b0;
        shadow_key[t][s] = '0;
        for (int w = 0; w < NumStats; w++) shadow_stats[t][s][w] = '0;
      end
    meas_on = 0; srv_keying = 0; ip_keying = 0;

    rst_n = 1'b0; start = 1'b0; in_cmd = 1'b0;
    in_request_id = '0; in_source_ip = '0; in_server_key = '0;
    in_start_tick = '0; in_stop_tick = '0; in_table_select = '0; in_slot_index = '0;
    in_clear_interval = 1'b0; in_clear_total = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;

    key_pool.push_back(32'hFFFF_FFFF);
    key_pool.push_back(32'h0000_0001);
    for (int k = 0; k < 68; k++) key_pool.push_back($urandom | 32'h1);

    // Directed rows. The first few run before measuring is switched on.
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_REQ, 0, 1, 1, 1));
    directed_rows.push_back(make_row(CMD_RECORD, 32'hFFFF_FFFF, 1, 1, 0, TICK_MAX,
                                     TAB_REQ, 0, 0, 0, 1));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_SRV, 63, 0, 0, 1));
    directed_rows.push_back(make_row(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 0, TICK_MAX, TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 0, TICK_MAX, TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_RECORD, 32'hFFFF_FFFF, 32'h0A0B_0C0D, 0,
                                     TICK_MAX, 0, TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_RECORD, 0, 32'h0A0B_0C0D, 0, 100, 250,
                                     TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_RECORD, 0, 0, 0, 5, 5, TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_REQ, 0, 1, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_REQ, 0, 0, 1, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_REQ, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_REQ, 1, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_SRV, 0, 1, 1, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_SRV, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_IP, 0, 0, 0, 0));
    directed_rows.push_back(make_row(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, TICK_MAX, TICK_MAX, TAB_BAD, 6'h3F,
                                     1, 1, 1));
    directed_rows.push_back(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_IP, 63, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (i == PreEnableRows) begin
        wait_drained();
        set_keying(1, 1, 1);
      end
      d = directed_rows[i];
      send_command(d.item, d.fixed, d.report);
    end
    // The ip row above needs ip keying without server keying.
    wait_drained();
    set_keying(1, 0, 1);
    send_command(make_row(CMD_RECORD, 7, 32'h0A0B_0C0D, 0, 0, 9, TAB_REQ, 0, 0, 0, 0).item,
                 0, none);
    send_command(make_row(CMD_READ, 0, 0, 0, 0, 0, TAB_IP, 0, 1, 1, 0).item, 0, none);

    // Random phases, each under a keying setup from the list (measure, server, ip).
    cfg_list = '{3'b110, 3'b100, 3'b101, 3'b111, 3'b011, 3'b111};
    foreach (cfg_list[p]) begin
      wait_drained();
      set_keying(cfg_list[p][2], cfg_list[p][1], cfg_list[p][0]);
      phase_items = 0;
      while (phase_items < 240) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) begin
          send_command(random_command(), 0, none);
          phase_items++;
        end
        if ($urandom_range(3) != 0) pause_sender($urandom_range(0, 30));
        // Now and then hold the sender until everything has come back.
        if ($urandom_range(15) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Ran %0d commands: %0d records (%0d with a drop), %0d reads, %0d results.",
             n_sent, n_records, n_drops, n_reads, n_seen);
    $display("Keying setups covered none, ip only, server only, both, and measuring off.");
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("keyed_latency_statistics_table_unit test passed");
    end else begin
      $display("keyed_latency_statistics_table_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
